// ===== hw/rtl/measurement_register_bank_macros.svh =====
// assertion macros used by the measurement register bank control rtl
`ifndef MEASUREMENT_REGISTER_BANK_MACROS_SVH
`define MEASUREMENT_REGISTER_BANK_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("measurement register bank check failed");

// next-cycle implication, checked out of reset
`define MRB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("measurement register bank check failed");

`endif

// ===== hw/rtl/mrb_pkg.sv =====
// types, constants and status codes of the measurement register bank
`default_nettype none

package mrb_pkg;

    localparam int NUM_VALUES      = 24;
    localparam int WORDS_PER_VALUE = 8;

    localparam int DATA_W      = 32;
    localparam int OFF_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int SEL_W       = 5;
    localparam int CTL_W       = 7;
    localparam int WEN_BIT     = 5;
    localparam int REN_BIT     = 6;
    localparam int STORE_DEPTH = NUM_VALUES * WORDS_PER_VALUE;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int IDX_FULL_W  = SEL_W + $clog2(WORDS_PER_VALUE) + 1;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_OFFSET  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WRONG_DIR   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_ENABLED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_SELECT  = 3'd4;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [OFF_W-1:0]  word_offset;
        logic [DATA_W-1:0] write_data;
    } in_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } store_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                use_mem;
        logic [CTL_W-1:0]    imm_data;
    } resp_info_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mrb_store.sv =====
// measurement word memory with per-entry valid bits and registered read
`default_nettype none

module mrb_store (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire mrb_pkg::store_req_t        req,
    output logic [mrb_pkg::DATA_W-1:0]      rdata,
    output logic                            rvalid
);
    import mrb_pkg::*;

    logic [DATA_W-1:0]      mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [DATA_W-1:0]      rdata_reg;
    logic                   rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[req.addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.addr] <= 1'b1;
            end
            if (req.rd_en) begin
                rvalid_reg <= valid_reg[req.addr];
            end
        end
    end

    assign rdata  = rdata_reg;
    assign rvalid = rvalid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mrb_ctrl.sv =====
// control register, access decode and store request generation
`default_nettype none
`include "measurement_register_bank_macros.svh"

module mrb_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  accept,
    input  wire mrb_pkg::in_item_t     item,
    output mrb_pkg::store_req_t        req,
    output mrb_pkg::resp_info_t        info
);
    import mrb_pkg::*;

    localparam logic [OFF_W-1:0] W_OFF  = OFF_W'(WORDS_PER_VALUE);
    localparam logic [OFF_W-1:0] W2_OFF = OFF_W'(2 * WORDS_PER_VALUE);
    localparam logic [OFF_W-1:0] LAST_K = OFF_W'(WORDS_PER_VALUE - 1);

    logic [CTL_W-1:0]      ctl_reg;
    logic [CTL_W-1:0]      ctl_next;
    logic [SEL_W-1:0]      sel;
    logic                  sel_ok;
    logic [CTL_W-1:0]      masked;
    logic                  masked_ok;
    logic                  in_wr_region;
    logic                  in_rd_region;
    logic [OFF_W-1:0]      off_m1;
    logic [OFF_W-1:0]      k_full;
    logic                  last;
    logic [IDX_FULL_W-1:0] idx_full;
    logic                  do_wr;
    logic                  do_rd;

    assign sel          = ctl_reg[SEL_W-1:0];
    assign sel_ok       = (sel != '0) && (sel <= SEL_W'(NUM_VALUES));
    assign masked       = item.write_data[CTL_W-1:0];
    assign masked_ok    = (masked[SEL_W-1:0] != '0)
                          && (masked[SEL_W-1:0] <= SEL_W'(NUM_VALUES));
    assign in_wr_region = (item.word_offset != '0) && (item.word_offset <= W_OFF);
    assign in_rd_region = (item.word_offset > W_OFF) && (item.word_offset <= W2_OFF);
    assign off_m1       = item.word_offset - OFF_W'(1);
    assign k_full       = in_rd_region ? (off_m1 - W_OFF) : off_m1;
    assign last         = (k_full == LAST_K);
    assign idx_full     = IDX_FULL_W'(sel - SEL_W'(1)) * IDX_FULL_W'(WORDS_PER_VALUE)
                          + IDX_FULL_W'(k_full);

    always_comb begin
        ctl_next      = ctl_reg;
        info.status   = ST_OK;
        info.use_mem  = 1'b0;
        info.imm_data = '0;
        do_wr         = 1'b0;
        do_rd         = 1'b0;
        if (item.word_offset == '0) begin
            if (item.cmd == CMD_WRITE) begin
                if ((masked != '0) && !masked_ok) begin
                    ctl_next    = '0;
                    info.status = ST_BAD_SELECT;
                end else begin
                    ctl_next = masked;
                end
            end else begin
                info.imm_data = ctl_reg;
            end
        end else if (in_wr_region) begin
            if (item.cmd != CMD_WRITE) begin
                info.status = ST_WRONG_DIR;
            end else if (!ctl_reg[WEN_BIT]) begin
                info.status = ST_NOT_ENABLED;
            end else if (!sel_ok) begin
                info.status = ST_BAD_SELECT;
            end else begin
                do_wr = 1'b1;
                if (last) begin
                    ctl_next[WEN_BIT]     = 1'b0;
                    ctl_next[SEL_W-1:0]   = '0;
                end
            end
        end else if (in_rd_region) begin
            if (item.cmd != CMD_READ) begin
                info.status = ST_WRONG_DIR;
            end else if (!ctl_reg[REN_BIT]) begin
                info.status = ST_NOT_ENABLED;
            end else if (!sel_ok) begin
                info.status = ST_BAD_SELECT;
            end else begin
                do_rd        = 1'b1;
                info.use_mem = 1'b1;
                if (last) begin
                    ctl_next[REN_BIT]     = 1'b0;
                    ctl_next[SEL_W-1:0]   = '0;
                end
            end
        end else begin
            info.status = ST_BAD_OFFSET;
        end
    end

    assign req.wr_en = accept && do_wr;
    assign req.rd_en = accept && do_rd;
    assign req.addr  = idx_full[ADDR_W-1:0];
    assign req.wdata = item.write_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (accept) begin
            ctl_reg <= ctl_next;
        end
    end

    `MRB_ASSERT_IMPL(a_sel_in_range, 1'b1, ctl_reg[SEL_W-1:0] <= SEL_W'(NUM_VALUES))
    `MRB_ASSERT_IMPL(a_store_ok_only, req.wr_en || req.rd_en, info.status == ST_OK)
    `MRB_ASSERT_NEXT(a_last_write_closes, req.wr_en && last, !ctl_reg[WEN_BIT] && (ctl_reg[SEL_W-1:0] == '0))

endmodule

`default_nettype wire

// ===== hw/rtl/measurement_register_bank.sv =====
// top level of the measurement register bank
`default_nettype none

// Register bank of NUM_VALUES measurement values of WORDS_PER_VALUE 32-bit
// words each, reached through one valid/ready request channel and one
// valid/ready response channel. Every request transfer yields exactly one
// response transfer, in order. Requests are taken one per cycle when the
// response side keeps up; a response passes through the registered read of
// the word memory and then through the response register. The memory carries
// a valid bit per word, so it reads as zero right after reset with no
// clearing pass.
module measurement_register_bank (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire mrb_pkg::in_item_t     s_payload,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output mrb_pkg::out_item_t         m_payload
);
    import mrb_pkg::*;

    logic              accept;
    logic              advance;
    store_req_t        req;
    resp_info_t        info;
    logic [DATA_W-1:0] rdata;
    logic              rvalid;
    logic              p1_valid_reg;
    resp_info_t        p1_info_reg;
    logic              m_valid_reg;
    out_item_t         m_payload_reg;
    out_item_t         m_payload_next;

    assign advance = p1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !p1_valid_reg || !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    mrb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_payload),
        .req     (req),
        .info    (info)
    );

    mrb_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rdata   (rdata),
        .rvalid  (rvalid)
    );

    always_comb begin
        m_payload_next.status = p1_info_reg.status;
        if (p1_info_reg.use_mem) begin
            m_payload_next.read_data = rvalid ? rdata : '0;
        end else begin
            m_payload_next.read_data = DATA_W'(p1_info_reg.imm_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                p1_valid_reg <= 1'b1;
            end else if (advance) begin
                p1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_info_reg <= info;
        end
        if (advance) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire
